// ===== hdl/srq_pkg.sv =====
// Shared types, widths and codes for the sorted ready queue.
// Used by every module of the block and by its checker; depends on nothing.
package srq_pkg;

    // Queue geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W     = 3;
    localparam int HANDLE_W = 8;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 16;
    localparam int STS_W    = 2;
    localparam int OCC_W    = 5;

    // Input tdata layout: handle, priority, time left
    localparam int IN_HANDLE_LSB = 0;
    localparam int IN_PRIO_LSB   = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_TIME_LSB   = IN_PRIO_LSB + PRIO_W;
    localparam int IN_DATA_W     = IN_TIME_LSB + TIME_W;

    // Output tdata layout: handle, priority, time left, status, occupancy, pad
    localparam int OUT_HANDLE_LSB = 0;
    localparam int OUT_PRIO_LSB   = OUT_HANDLE_LSB + HANDLE_W;
    localparam int OUT_TIME_LSB   = OUT_PRIO_LSB + PRIO_W;
    localparam int OUT_STS_LSB    = OUT_TIME_LSB + TIME_W;
    localparam int OUT_OCC_LSB    = OUT_STS_LSB + STS_W;
    localparam int OUT_USED_W     = OUT_OCC_LSB + OCC_W;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_PRIO = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TIME = 3'd2;
    localparam logic [OP_W-1:0] OP_POP      = 3'd3;
    localparam logic [OP_W-1:0] OP_POLL     = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd5;

    // Result status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic              capture;     // latch request and compare mask
        logic              apply;       // update list and load result register
        logic              insert;      // open a gap at the insert slot
        logic              pop_head;    // remove slot 0, close the gap
        logic              pop_tail;    // drop the last slot
        logic              show_entry;  // result carries an entry
        logic              read_tail;   // entry comes from the tail, else head
        logic [STS_W-1:0]  code;        // result status
    } srq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
    } srq_sts_t;

endpackage

// ===== hdl/srq_first_zero.sv =====
// Finds the lowest slot whose keep flag is clear (the insert position).
// Depends on srq_pkg.
module srq_first_zero (
    input  logic [srq_pkg::DEPTH-1:0] keep,
    output logic [srq_pkg::IDX_W-1:0] pos
);
    import srq_pkg::*;

    logic [DEPTH-1:0] gap;
    logic [DEPTH-1:0] onehot;

    // Isolate the lowest clear bit with one add
    assign gap    = ~keep;
    assign onehot = gap & (~gap + DEPTH'(1));

    // One-hot to index
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (onehot[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

endmodule

// ===== hdl/srq_dp.sv =====
// Datapath: entry slots, count, request latch, compare mask, result register.
// Depends on srq_pkg and srq_first_zero.
module srq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srq_pkg::srq_cmd_t             cmd,
    output srq_pkg::srq_sts_t             sts,
    input  logic [srq_pkg::OP_W-1:0]      in_op,
    input  logic [srq_pkg::IN_DATA_W-1:0] in_data,
    output logic [srq_pkg::OUT_DATA_W-1:0] out_data
);
    import srq_pkg::*;

    // Entry slots, slot 0 is the head
    logic [HANDLE_W-1:0] handle_reg [DEPTH];
    logic [PRIO_W-1:0]   prio_reg   [DEPTH];
    logic [TIME_W-1:0]   time_reg   [DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // Latched request
    logic [OP_W-1:0]     op_reg;
    logic [HANDLE_W-1:0] req_handle_reg;
    logic [PRIO_W-1:0]   req_prio_reg;
    logic [TIME_W-1:0]   req_time_reg;
    logic [DEPTH-1:0]    keep_reg;
    logic [DEPTH-1:0]    keep_next;

    // Result register
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [STS_W-1:0]    out_sts_reg;
    logic [OCC_W-1:0]    out_occ_reg;

    logic [HANDLE_W-1:0] in_handle;
    logic [PRIO_W-1:0]   in_prio;
    logic [TIME_W-1:0]   in_time;
    logic [IDX_W-1:0]    ins_pos;
    logic [CNT_W-1:0]    count_m1;
    logic [IDX_W-1:0]    rd_idx;

    assign in_handle = in_data[IN_HANDLE_LSB +: HANDLE_W];
    assign in_prio   = in_data[IN_PRIO_LSB +: PRIO_W];
    assign in_time   = in_data[IN_TIME_LSB +: TIME_W];

    // Per-slot compare: slot stays ahead of the new entry
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CNT_W'(i) >= count_reg)
            begin
                keep_next[i] = 1'b0;
            end
            else if (in_op == OP_INS_PRIO)
            begin
                keep_next[i] = (prio_reg[i] >= in_prio);
            end
            else if (in_op == OP_INS_TIME)
            begin
                keep_next[i] = (time_reg[i] <= in_time);
            end
            else
            begin
                keep_next[i] = 1'b0;
            end
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg         <= in_op;
            req_handle_reg <= in_handle;
            req_prio_reg   <= in_prio;
            req_time_reg   <= in_time;
            keep_reg       <= keep_next;
        end
    end

    srq_first_zero u_first_zero (
        .keep (keep_reg),
        .pos  (ins_pos)
    );

    // Slot shifting: insert moves slots at and after the gap down by one,
    // head removal moves every slot up by one
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

        always_ff @(posedge clk)
        begin
            if (cmd.apply)
            begin
                if (cmd.insert)
                begin
                    if (ins_pos == IDX_W'(g))
                    begin
                        handle_reg[g] <= req_handle_reg;
                        prio_reg[g]   <= req_prio_reg;
                        time_reg[g]   <= req_time_reg;
                    end
                    else if (ins_pos < IDX_W'(g))
                    begin
                        handle_reg[g] <= handle_reg[PREV];
                        prio_reg[g]   <= prio_reg[PREV];
                        time_reg[g]   <= time_reg[PREV];
                    end
                end
                else if (cmd.pop_head)
                begin
                    handle_reg[g] <= handle_reg[NEXT];
                    prio_reg[g]   <= prio_reg[NEXT];
                    time_reg[g]   <= time_reg[NEXT];
                end
            end
        end
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.apply)
        begin
            if (cmd.insert)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (cmd.pop_head || cmd.pop_tail)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Read slot: head or tail
    assign count_m1 = count_reg - CNT_W'(1);
    assign rd_idx   = cmd.read_tail ? count_m1[IDX_W-1:0] : '0;

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            out_handle_reg <= cmd.show_entry ? handle_reg[rd_idx] : '0;
            out_prio_reg   <= cmd.show_entry ? prio_reg[rd_idx] : '0;
            out_time_reg   <= cmd.show_entry ? time_reg[rd_idx] : '0;
            out_sts_reg    <= cmd.code;
            out_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign out_data = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_occ_reg, out_sts_reg,
                       out_time_reg, out_prio_reg, out_handle_reg};

    // Status toward the controller
    assign sts.op    = op_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg >= CNT_W'(DEPTH));

endmodule

// ===== hdl/srq_ctrl.sv =====
// Controller: accepts one request, decodes it against queue status and
// drives the datapath and the output valid. Depends on srq_pkg.
module srq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  srq_pkg::srq_sts_t sts,
    output srq_pkg::srq_cmd_t cmd
);
    import srq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Command decode
    always_comb
    begin
        cmd         = '0;
        cmd.code    = STS_OK;
        cmd.capture = in_valid && (state_reg == S_IDLE);
        if (state_reg == S_APPLY && out_free)
        begin
            cmd.apply = 1'b1;
            unique case (sts.op)
                OP_PUSH, OP_INS_PRIO, OP_INS_TIME:
                begin
                    if (sts.full)
                        cmd.code = STS_FULL;
                    else
                        cmd.insert = 1'b1;
                end
                OP_POP:
                begin
                    if (sts.empty)
                        cmd.code = STS_EMPTY;
                    else
                    begin
                        cmd.show_entry = 1'b1;
                        cmd.pop_head   = 1'b1;
                    end
                end
                OP_POLL:
                begin
                    if (sts.empty)
                        cmd.code = STS_EMPTY;
                    else
                    begin
                        cmd.show_entry = 1'b1;
                        cmd.read_tail  = 1'b1;
                        cmd.pop_tail   = 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    if (sts.empty)
                        cmd.code = STS_EMPTY;
                    else
                        cmd.show_entry = 1'b1;
                end
                default:
                begin
                    cmd.code = STS_OK;
                end
            endcase
        end
    end

    // Next state and output valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.apply)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/sorted_ready_queue.sv =====
// Sorted ready queue top level: stream ports around controller and datapath.
// Depends on srq_pkg, srq_ctrl and srq_dp.
//
//   channel   direction  tdata (low bit up)                      tuser
//   s_axis    in         handle, priority, time left             opcode
//   m_axis    out        handle, priority, time left, status,    -
//                        occupancy, zero pad
//
// The accept cycle latches an item and its per-slot compare mask; the apply
// state then picks the insert slot and shifts the list.
// The apply cycle waits while the output register holds an untaken result;
// a new item is accepted as soon as the apply has happened.
// Reset empties the queue at once; there is no clearing pass.
module sorted_ready_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [srq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // handle, priority, time left
    input  logic [srq_pkg::OP_W-1:0]       s_axis_tuser,  // opcode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [srq_pkg::OUT_DATA_W-1:0] m_axis_tdata   // handle, priority, time left,
                                                          // status, occupancy, pad
);
    import srq_pkg::*;

    srq_cmd_t cmd;
    srq_sts_t sts;

    srq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    srq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_op    (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

// ===== hdl/srq_checker.sv =====
// Port-level checks for the sorted ready queue, bound to the top level.
// Depends on srq_pkg and sorted_ready_queue.
module srq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [srq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import srq_pkg::*;

    logic [STS_W-1:0] res_sts;
    logic [OCC_W-1:0] res_occ;
    logic [OUT_STS_LSB-1:0] res_entry;

    assign res_sts   = m_axis_tdata[OUT_STS_LSB +: STS_W];
    assign res_occ   = m_axis_tdata[OUT_OCC_LSB +: OCC_W];
    assign res_entry = m_axis_tdata[OUT_STS_LSB-1:0];

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous item in work");

    // Dropped insert reports a full queue and no entry
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res_sts == STS_FULL)
            |-> (res_occ == OCC_W'(DEPTH)) && (res_entry == '0))
        else $error("full status with wrong occupancy or entry");

    // Empty status means nothing held and no entry
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res_sts == STS_EMPTY) |-> (res_occ == '0) && (res_entry == '0))
        else $error("empty status with entries or nonzero entry");

endmodule

bind sorted_ready_queue srq_checker u_srq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
